// ===== design/tfrc_pkg.sv =====
// Package for the four-register execute unit.
// Holds opcode codes, register file type and the result/write-back structs.
// No dependencies.
package tfrc_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned NumRegs   = 4;
  localparam int unsigned RegIdxW   = 2;
  localparam int unsigned SkipW     = 2;

  typedef enum logic [1:0] {
    OP_CMP_PRINT = 2'b00,
    OP_ADD       = 2'b01,
    OP_SUB       = 2'b10,
    OP_LDI       = 2'b11
  } opcode_t;

  localparam logic [SkipW-1:0] SKIP_NONE = 2'd0;
  localparam logic [SkipW-1:0] SKIP_ONE  = 2'd1;
  localparam logic [SkipW-1:0] SKIP_TWO  = 2'd2;

  typedef logic [NumRegs-1:0][DataWidth-1:0] regfile_t;

  typedef struct packed {
    logic                 executed;
    logic                 print_valid;
    logic [RegIdxW-1:0]   print_reg;
    logic [DataWidth-1:0] print_value;
    logic                 show_decimal;
    logic                 show_hex;
    logic                 show_char;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [RegIdxW-1:0]   addr;
    logic [DataWidth-1:0] data;
  } writeback_t;

endpackage

// ===== design/tfrc_exec.sv =====
// Combinational decode and execute for one instruction.
// Depends on tfrc_pkg for the opcode codes, register file type and structs.
module tfrc_exec
  import tfrc_pkg::*;
(
  input  logic [7:0]       instruction,
  input  regfile_t         regs,
  input  logic [SkipW-1:0] skip_count,
  output result_t          result,
  output writeback_t       wb,
  output logic [SkipW-1:0] skip_count_next
);

  logic [RegIdxW-1:0] rd;
  logic [RegIdxW-1:0] rs;
  logic [RegIdxW-1:0] rt;
  logic [RegIdxW-1:0] pr;
  opcode_t            op;

  assign op = opcode_t'(instruction[7:6]);
  assign rd = instruction[5:4];
  assign rs = instruction[3:2];
  assign rt = instruction[1:0];
  assign pr = instruction[4:3];

  always_comb begin
    result          = '0;
    wb              = '0;
    skip_count_next = skip_count;
    if (skip_count != SKIP_NONE) begin
      // A skipped instruction writes no register and prints nothing; it only counts the skip counter down.
      skip_count_next = skip_count - SKIP_ONE;
    end else begin
      result.executed = 1'b1;
      unique case (op)
        OP_ADD: begin
          wb.en   = 1'b1;
          wb.addr = rd;
          wb.data = regs[rs] + regs[rt];
        end
        OP_SUB: begin
          wb.en   = 1'b1;
          wb.addr = rd;
          wb.data = regs[rs] - regs[rt];
        end
        OP_LDI: begin
          wb.en   = 1'b1;
          wb.addr = rd;
          wb.data = {{5{instruction[3]}}, instruction[2:0]};
        end
        OP_CMP_PRINT: begin
          if (instruction[5]) begin
            if (regs[rs] == regs[rt]) begin
              skip_count_next = instruction[4] ? SKIP_TWO : SKIP_ONE;
            end
          end else begin
            result.print_valid  = 1'b1;
            result.print_reg    = pr;
            result.print_value  = regs[pr];
            result.show_decimal = instruction[2];
            result.show_hex     = instruction[1];
            result.show_char    = instruction[0];
          end
        end
        default: begin
          wb = '0;
        end
      endcase
    end
  end

endmodule

// ===== design/tiny_four_register_cpu_execute_unit.sv =====
// Top level of the four-register 8-bit instruction execute unit.
// Depends on tfrc_pkg and instantiates tfrc_exec.
//
// This unit executes one 8-bit instruction per request on four 8-bit
// registers and returns exactly one result request for each instruction, in
// order. An accepted instruction is held in an input register; in the cycle
// it leaves that register it is decoded and executed in one pass of short
// logic, the register file and skip counter are updated, and the result is
// captured in an output register. A new instruction can be accepted every
// cycle as long as results are taken. When the output register is free, an
// accepted instruction moves from the input register to the output register.
// Because each instruction executes only when it moves into the output
// register, it always sees the register file left by the instruction before
// it. Throughput is set by the downstream side alone: when the result is not
// taken, the output register holds it while the input register can still
// take one further instruction. After reset the register file and the skip
// counter are zero and the input and output registers hold nothing valid.
module tiny_four_register_cpu_execute_unit
  import tfrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_ready,
  input  logic [7:0]        instruction,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              executed,
  output logic              print_valid,
  output logic [1:0]        print_reg,
  output logic signed [7:0] print_value,
  output logic              show_decimal,
  output logic              show_hex,
  output logic              show_char
);

  // Input stage.
  logic       instr_held;
  logic [7:0] instr_reg;

  // Architectural state.
  regfile_t         regs;
  logic [SkipW-1:0] skip_count;

  // Output stage.
  result_t result_reg;

  // Execute stage signals.
  result_t          exec_result;
  writeback_t       exec_wb;
  logic [SkipW-1:0] skip_count_next;
  logic             exec_fire;

  // The held instruction executes when the output register is free or is
  // being emptied in this same cycle.
  assign exec_fire   = instr_held && (!result_valid || result_ready);
  assign instr_ready = !instr_held || exec_fire;

  tfrc_exec u_exec (
    .instruction     (instr_reg),
    .regs            (regs),
    .skip_count      (skip_count),
    .result          (exec_result),
    .wb              (exec_wb),
    .skip_count_next (skip_count_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      instr_held <= 1'b0;
    end else if (instr_ready) begin
      instr_held <= instr_valid;
    end
    if (instr_ready && instr_valid) begin
      instr_reg <= instruction;
    end
  end

  // Register file and skip counter update only when an instruction executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs       <= '0;
      skip_count <= SKIP_NONE;
    end else if (exec_fire) begin
      skip_count <= skip_count_next;
      if (exec_wb.en) begin
        regs[exec_wb.addr] <= exec_wb.data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (exec_fire) begin
      result_reg <= exec_result;
    end
  end

  assign executed     = result_reg.executed;
  assign print_valid  = result_reg.print_valid;
  assign print_reg    = result_reg.print_reg;
  assign print_value  = $signed(result_reg.print_value);
  assign show_decimal = result_reg.show_decimal;
  assign show_hex     = result_reg.show_hex;
  assign show_char    = result_reg.show_char;

endmodule
